// File: sv/sad_pkg.sv
// shared constants, types and register codes for the shock amplitude detector
package sad_pkg;

    // block and hold-off configuration
    localparam int BLOCK_LEN    = 16;
    localparam int HOLD_BLOCKS  = 12;
    localparam int STARTUP_HOLD = 625;
    localparam int HOLD_MAX     = (STARTUP_HOLD > HOLD_BLOCKS) ? STARTUP_HOLD : HOLD_BLOCKS;

    // field and state widths
    localparam int SMP_W     = 12;
    localparam int CNT_W     = 4;
    localparam int SUM_W     = 16;
    localparam int BASE_W    = 16;
    localparam int HOLD_W    = 10;
    localparam int NOISE_W   = 12;
    localparam int ELAPSED_W = 17;
    localparam int WIN_W     = 16;
    localparam int RECIP_W   = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // reset values
    localparam logic [BASE_W-1:0]    BASE_RESET     = 16'h8000;
    localparam logic [SMP_W-1:0]     WARN_THR_RESET = 12'd14;
    localparam logic [SMP_W-1:0]     MAIN_THR_RESET = 12'd100;
    localparam logic [RECIP_W-1:0]   DECAY_RESET    = 16'd45247;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX    = '1;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ARMED     = 3'd0,
        CFG_WARN_THR  = 3'd1,
        CFG_MAIN_THR  = 3'd2,
        CFG_NOISE_WIN = 3'd3,
        CFG_DECAY     = 3'd4
    } t_cfg_idx;

    // configuration register set
    typedef struct packed {
        logic               armed;
        logic [SMP_W-1:0]   warn_thr;
        logic [SMP_W-1:0]   main_thr;
        logic [WIN_W-1:0]   noise_win;
        logic [RECIP_W-1:0] decay_recip;
    } t_cfg;

    // completed block handed to the detector
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [SMP_W-1:0] min;
        logic [SMP_W-1:0] max;
    } t_blk;

    // one result item
    typedef struct packed {
        logic               main_hit;
        logic               warn_hit;
        logic [SMP_W-1:0]   amplitude;
        logic [BASE_W-1:0]  baseline_level;
        logic [NOISE_W-1:0] noise_peak;
    } t_res;

endpackage

// File: sv/sad_smp_if.sv
// sample channel: valid/ready with one adc sample
interface sad_smp_if;
    import sad_pkg::*;

    logic             valid;
    logic             ready;
    logic [SMP_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink (input valid, input adc_sample, output ready);
endinterface

// File: sv/sad_res_if.sv
// result channel: valid/ready with one block result
interface sad_res_if;
    import sad_pkg::*;

    logic               valid;
    logic               ready;
    logic               main_hit;
    logic               warn_hit;
    logic [SMP_W-1:0]   amplitude;
    logic [BASE_W-1:0]  baseline_level;
    logic [NOISE_W-1:0] noise_peak;

    modport source (output valid, output main_hit, output warn_hit, output amplitude,
                    output baseline_level, output noise_peak, input ready);
    modport sink (input valid, input main_hit, input warn_hit, input amplitude,
                  input baseline_level, input noise_peak, output ready);
endinterface

// File: sv/sad_cfg.sv
// configuration registers and noise tracker clear strobe
module sad_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sad_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sad_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output sad_pkg::t_cfg                  o_cfg,
    output logic                           o_noise_clr
);
    import sad_pkg::*;

    t_cfg r_cfg;

    // register writes, masked to register width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.armed       <= 1'b0;
            r_cfg.warn_thr    <= WARN_THR_RESET;
            r_cfg.main_thr    <= MAIN_THR_RESET;
            r_cfg.noise_win   <= '0;
            r_cfg.decay_recip <= DECAY_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ARMED:     r_cfg.armed       <= i_cfg_data[0];
                CFG_WARN_THR:  r_cfg.warn_thr    <= i_cfg_data[SMP_W-1:0];
                CFG_MAIN_THR:  r_cfg.main_thr    <= i_cfg_data[SMP_W-1:0];
                CFG_NOISE_WIN: r_cfg.noise_win   <= i_cfg_data[WIN_W-1:0];
                CFG_DECAY:     r_cfg.decay_recip <= i_cfg_data[RECIP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // arming or a new noise window restarts noise tracking
    assign o_noise_clr = i_cfg_we &&
                         (((t_cfg_idx'(i_cfg_idx) == CFG_ARMED) && i_cfg_data[0]) ||
                          (t_cfg_idx'(i_cfg_idx) == CFG_NOISE_WIN));
    assign o_cfg = r_cfg;
endmodule

// File: sv/sad_accum.sv
// per-sample block accumulator: running sum, minimum and maximum
module sad_accum (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [sad_pkg::SMP_W-1:0] i_sample,
    output logic                      o_blk_valid,
    input  logic                      i_blk_ready,
    output sad_pkg::t_blk             o_blk
);
    import sad_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [SUM_W-1:0] r_sum;
    logic [SMP_W-1:0] r_min;
    logic [SMP_W-1:0] r_max;
    logic             r_blk_valid;
    t_blk             r_blk;

    logic             w_first;
    logic             w_last;
    logic             w_take;
    logic [SUM_W-1:0] n_sum;
    logic [SMP_W-1:0] n_min;
    logic [SMP_W-1:0] n_max;

    // block position; the last sample needs room in the block handoff
    assign w_first = (r_count == '0);
    assign w_last  = (r_count == CNT_W'(BLOCK_LEN - 1));
    assign o_ready = !w_last || !r_blk_valid || i_blk_ready;
    assign w_take  = i_valid && o_ready;

    // running statistics including the incoming sample
    always_comb begin
        if (w_first) begin
            n_sum = SUM_W'(i_sample);
            n_min = i_sample;
            n_max = i_sample;
        end else begin
            n_sum = r_sum + SUM_W'(i_sample);
            n_min = (i_sample < r_min) ? i_sample : r_min;
            n_max = (i_sample > r_max) ? i_sample : r_max;
        end
    end

    // sample counter and handoff valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_blk_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_count <= w_last ? '0 : r_count + CNT_W'(1);
            end
            if (w_take && w_last) begin
                r_blk_valid <= 1'b1;
            end else if (i_blk_ready) begin
                r_blk_valid <= 1'b0;
            end
        end
    end

    // statistics and completed block payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_sum <= n_sum;
            r_min <= n_min;
            r_max <= n_max;
        end
        if (w_take && w_last) begin
            r_blk.sum <= n_sum;
            r_blk.min <= n_min;
            r_blk.max <= n_max;
        end
    end

    assign o_blk_valid = r_blk_valid;
    assign o_blk       = r_blk;
endmodule

// File: sv/sad_detect.sv
// end-of-block detector: baseline, hold-offs, triggers, noise peak, result register
module sad_detect (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sad_pkg::t_cfg i_cfg,
    input  logic          i_noise_clr,
    input  logic          i_blk_valid,
    output logic          o_blk_ready,
    input  sad_pkg::t_blk i_blk,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output sad_pkg::t_res o_res
);
    import sad_pkg::*;

    localparam int MEAN_W = SUM_W + 4;
    localparam int ACC_W  = MEAN_W + 1;
    localparam int PROD_W = NOISE_W + RECIP_W;

    logic [BASE_W-1:0]    r_base;
    logic [HOLD_W-1:0]    r_main_hold;
    logic [HOLD_W-1:0]    r_warn_hold;
    logic [NOISE_W-1:0]   r_noise;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic                 r_out_valid;
    t_res                 r_out;

    logic                 w_load;
    logic [MEAN_W-1:0]    w_sum16;
    logic [MEAN_W-1:0]    w_mean16;
    logic [ACC_W-1:0]     w_base_acc;
    logic [BASE_W-1:0]    n_base;
    logic [HOLD_W-1:0]    w_main_dec;
    logic [HOLD_W-1:0]    w_warn_dec;
    logic [ELAPSED_W-1:0] w_elapsed_inc;
    logic [BASE_W-1:0]    w_hi;
    logic [BASE_W-1:0]    w_lo;
    logic [BASE_W-1:0]    w_dev_hi;
    logic [BASE_W-1:0]    w_dev_lo;
    logic [BASE_W-1:0]    w_dev;
    logic [SMP_W-1:0]     w_amp;
    logic                 w_main_hit;
    logic                 w_warn_hit;
    logic                 w_quiet;
    logic                 w_window_done;
    logic [PROD_W-1:0]    w_prod;
    logic [NOISE_W-1:0]   w_decayed;
    logic [HOLD_W-1:0]    n_main_hold;
    logic [HOLD_W-1:0]    n_warn_hold;
    logic [NOISE_W-1:0]   n_noise;
    logic [ELAPSED_W-1:0] n_elapsed;

    // a block moves on when the result register is free or being drained
    assign o_blk_ready = !r_out_valid || i_res_ready;
    assign w_load      = i_blk_valid && o_blk_ready;

    // scaled mean and slow baseline: (15 * old + mean) / 16
    assign w_sum16    = {i_blk.sum, 4'b0};
    assign w_mean16   = MEAN_W'(w_sum16 / BLOCK_LEN);
    assign w_base_acc = ACC_W'({r_base, 4'b0}) - ACC_W'(r_base) + ACC_W'(w_mean16);
    assign n_base     = w_base_acc[BASE_W+3:4];

    // countdowns before any trigger decision
    assign w_main_dec    = (r_main_hold != '0) ? r_main_hold - HOLD_W'(1) : r_main_hold;
    assign w_warn_dec    = (r_warn_hold != '0) ? r_warn_hold - HOLD_W'(1) : r_warn_hold;
    assign w_elapsed_inc = (r_elapsed != ELAPSED_MAX) ? r_elapsed + ELAPSED_W'(1) : r_elapsed;

    // peak deviation of the block extremes from the new baseline
    assign w_hi     = {i_blk.max, 4'b0};
    assign w_lo     = {i_blk.min, 4'b0};
    assign w_dev_hi = (w_hi > n_base) ? w_hi - n_base : '0;
    assign w_dev_lo = (n_base > w_lo) ? n_base - w_lo : '0;
    assign w_dev    = (w_dev_hi > w_dev_lo) ? w_dev_hi : w_dev_lo;
    assign w_amp    = i_cfg.armed ? w_dev[BASE_W-1:4] : '0;

    // trigger priority: main, then warn, then quiet block
    assign w_main_hit = i_cfg.armed && (w_amp > i_cfg.main_thr) && (w_main_dec == '0);
    assign w_warn_hit = i_cfg.armed && !w_main_hit && (w_amp > i_cfg.warn_thr) &&
                        (w_warn_dec == '0);
    assign w_quiet    = i_cfg.armed && !w_main_hit && !w_warn_hit &&
                        (w_main_dec == '0) && (w_warn_dec == '0);

    // noise peak decay; a level that would not shrink drops to zero
    assign w_prod        = PROD_W'(r_noise) * PROD_W'(i_cfg.decay_recip);
    assign w_decayed     = w_prod[PROD_W-1:RECIP_W];
    assign w_window_done = (w_elapsed_inc > ELAPSED_W'(i_cfg.noise_win));

    // next hold-off and noise state
    always_comb begin
        n_main_hold = (w_main_hit || w_quiet) ? HOLD_W'(HOLD_BLOCKS) : w_main_dec;
        n_warn_hold = (w_warn_hit || w_quiet) ? HOLD_W'(HOLD_BLOCKS) : w_warn_dec;
        n_noise     = r_noise;
        n_elapsed   = w_elapsed_inc;
        if (w_quiet && w_window_done) begin
            n_noise   = (w_decayed == r_noise) ? '0 : w_decayed;
            n_elapsed = '0;
        end else if (w_quiet && (w_amp > r_noise)) begin
            n_noise   = w_amp;
            n_elapsed = '0;
        end
    end

    // detector state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= BASE_RESET;
            r_main_hold <= HOLD_W'(STARTUP_HOLD);
            r_warn_hold <= HOLD_W'(STARTUP_HOLD);
            r_noise     <= '0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_base      <= n_base;
                r_main_hold <= n_main_hold;
                r_warn_hold <= n_warn_hold;
            end
            if (i_noise_clr) begin
                r_noise   <= '0;
                r_elapsed <= '0;
            end else if (w_load) begin
                r_noise   <= n_noise;
                r_elapsed <= n_elapsed;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.main_hit       <= w_main_hit;
            r_out.warn_hit       <= w_warn_hit;
            r_out.amplitude      <= w_amp;
            r_out.baseline_level <= n_base;
            r_out.noise_peak     <= n_noise;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

`ifndef SYNTHESIS
    // the two triggers exclude each other
    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.main_hit && r_out.warn_hit))
        else $error("main and warn hit in the same result");

    // a trigger needs a nonzero deviation
    a_hit_amp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.main_hit || r_out.warn_hit)) |-> (r_out.amplitude != '0))
        else $error("trigger with zero amplitude");

    // a main trigger rearms the main hold-off
    a_main_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_main_hit && !i_noise_clr) |=> (r_main_hold == HOLD_W'(HOLD_BLOCKS)))
        else $error("main hold-off not reloaded after main trigger");

    // hold-offs never exceed their largest load value
    a_hold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_main_hold <= HOLD_W'(HOLD_MAX)) && (r_warn_hold <= HOLD_W'(HOLD_MAX)))
        else $error("hold-off out of range");
`endif
endmodule

// File: sv/shock_amplitude_detector.sv
// top level of the shock amplitude detector
//
// i_smp carries raw 12-bit adc samples; a sample transfers on a clock edge with
// valid and ready high. Samples are grouped into blocks of BLOCK_LEN (16), and
// each completed block gives one transfer on o_res with the trigger flags, the
// peak deviation, the updated baseline and the tracked noise peak.
// Throughput: one sample per cycle while o_res takes results. After the last
// sample of a block transfers, the block passes the block handoff register and
// then the result register before o_res.valid rises.
// Stall: a waiting result sits in the result register while samples keep
// flowing; the next completed block waits in the block handoff register, and
// the last sample of the block after that waits at i_smp until o_res.ready
// drains the result.
// Configuration: i_cfg_we writes register i_cfg_idx from i_cfg_data on the
// clock edge, with no wait; write only while no block is in flight. Arming,
// or writing the noise window, restarts noise tracking.
// Reset (synchronous, i_rst_n low): block position cleared, baseline 32768,
// hold-offs at the startup value, noise tracker cleared, registers at their
// defaults, and no result pending.
module shock_amplitude_detector (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sad_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sad_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sad_smp_if.sink                        i_smp,
    sad_res_if.source                      o_res
);
    import sad_pkg::*;

    t_cfg w_cfg;
    logic w_noise_clr;
    logic w_blk_valid;
    logic w_blk_ready;
    t_blk w_blk;
    logic w_res_valid;
    t_res w_res;

    // configuration registers
    sad_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg),
        .o_noise_clr (w_noise_clr)
    );

    // sample accumulation
    sad_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_smp.valid),
        .o_ready     (i_smp.ready),
        .i_sample    (i_smp.adc_sample),
        .o_blk_valid (w_blk_valid),
        .i_blk_ready (w_blk_ready),
        .o_blk       (w_blk)
    );

    // end-of-block detection
    sad_detect u_detect (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_noise_clr (w_noise_clr),
        .i_blk_valid (w_blk_valid),
        .o_blk_ready (w_blk_ready),
        .i_blk       (w_blk),
        .o_res_valid (w_res_valid),
        .i_res_ready (o_res.ready),
        .o_res       (w_res)
    );

    // result channel
    assign o_res.valid          = w_res_valid;
    assign o_res.main_hit       = w_res.main_hit;
    assign o_res.warn_hit       = w_res.warn_hit;
    assign o_res.amplitude      = w_res.amplitude;
    assign o_res.baseline_level = w_res.baseline_level;
    assign o_res.noise_peak     = w_res.noise_peak;
endmodule
